@@ hdl/mpmb_pkg.sv @@
`timescale 1ns / 1ps

package mpmb_pkg;

    localparam int PORTS_DEFAULT      = 64;
    localparam int RING_DEPTH_DEFAULT = 16;
    localparam int MSG_BITS_DEFAULT   = 64;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_SEND   = 2'd1,
        KIND_RECV   = 2'd2,
        KIND_CLOSE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_NO_FREE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_META,
        BK_SLOT
    } back_state_t;

    typedef struct packed {
        kind_t        kind;
        logic [5:0]   port;
        logic [15:0]  owner_id;
        logic [63:0]  message;
    } req_t;

    typedef struct packed {
        status_t      status;
        logic [5:0]   new_port;
        logic [63:0]  received;
    } rsp_t;

    typedef struct packed {
        kind_t        kind;
        logic         in_range;
        logic [5:0]   port;
        logic [15:0]  owner_id;
        logic [63:0]  message;
    } cmd_t;

endpackage

@@ hdl/mpmb_ram.sv @@
`timescale 1ns / 1ps

module mpmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mpmb_front.sv @@
`timescale 1ns / 1ps

module mpmb_front #(
    parameter int PORTS = mpmb_pkg::PORTS_DEFAULT
) (
    input  logic           req_valid,
    output logic           req_stall,
    input  mpmb_pkg::req_t req,
    input  logic           q_full,
    output logic           push,
    output mpmb_pkg::cmd_t cmd
);

    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

    always_comb
    begin
        cmd.kind     = req.kind;
        cmd.port     = req.port;
        cmd.owner_id = req.owner_id;
        cmd.message  = req.message;
        cmd.in_range = (req.port != '0) && (32'(req.port) < PORTS);
    end

endmodule

@@ hdl/mpmb_queue.sv @@
`timescale 1ns / 1ps

module mpmb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpmb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output mpmb_pkg::cmd_t head
);

    localparam int DEPTH = mpmb_pkg::QUEUE_DEPTH;
    localparam int QA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpmb_pkg::cmd_t   entries_reg [DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  wr_ptr_next;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] p);
        return (p == QA_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/mpmb_back.sv @@
`timescale 1ns / 1ps

module mpmb_back #(
    parameter int PORTS      = mpmb_pkg::PORTS_DEFAULT,
    parameter int RING_DEPTH = mpmb_pkg::RING_DEPTH_DEFAULT,
    parameter int MSG_BITS   = mpmb_pkg::MSG_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mpmb_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mpmb_pkg::rsp_t rsp
);

    localparam int PORT_W  = $clog2(PORTS);
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int SLOTS   = PORTS * RING_DEPTH;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int META_W  = 16 + 2 * PTR_W + FILL_W;

    typedef struct packed {
        logic [15:0]       owner;
        logic [PTR_W-1:0]  rptr;
        logic [PTR_W-1:0]  wptr;
        logic [FILL_W-1:0] fill;
    } meta_t;

    mpmb_pkg::back_state_t state_reg;
    mpmb_pkg::back_state_t state_next;
    logic [PORTS-1:0]      in_use_reg;
    logic [PORTS-1:0]      in_use_next;
    mpmb_pkg::cmd_t        cur_reg;
    mpmb_pkg::cmd_t        cur_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    mpmb_pkg::rsp_t        out_reg;
    mpmb_pkg::rsp_t        out_next;

    logic                  out_free;
    logic                  free_found;
    logic [PORT_W-1:0]     free_idx;
    logic [PORT_W-1:0]     q_idx;
    logic [PORT_W-1:0]     cur_idx;
    meta_t                 meta;
    meta_t                 meta_wr;

    logic                  meta_we;
    logic [PORT_W-1:0]     meta_waddr;
    logic                  meta_re;
    logic [META_W-1:0]     meta_rdata;
    logic                  slot_we;
    logic [SLOT_AW-1:0]    slot_waddr;
    logic                  slot_re;
    logic [SLOT_AW-1:0]    slot_raddr;
    logic [MSG_BITS-1:0]   slot_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_addr(input logic [PORT_W-1:0] idx,
                                                     input logic [PTR_W-1:0] ptr);
        return SLOT_AW'(idx) * SLOT_AW'(RING_DEPTH) + SLOT_AW'(ptr);
    endfunction

    assign q_idx   = PORT_W'(q_cmd.port);
    assign cur_idx = PORT_W'(cur_reg.port);
    assign meta    = meta_t'(meta_rdata);

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PORTS - 1; i >= 1; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = PORT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_use_next    = in_use_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        q_pop          = 1'b0;
        meta_we        = 1'b0;
        meta_waddr     = cur_idx;
        meta_wr        = meta;
        meta_re        = 1'b0;
        slot_we        = 1'b0;
        slot_waddr     = slot_addr(cur_idx, meta.wptr);
        slot_re        = 1'b0;
        slot_raddr     = slot_addr(cur_idx, meta.rptr);

        case (state_reg)
            mpmb_pkg::BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop             = 1'b1;
                    cur_next          = q_cmd;
                    out_next.status   = mpmb_pkg::ST_OK;
                    out_next.new_port = '0;
                    out_next.received = '0;
                    if (q_cmd.kind == mpmb_pkg::KIND_CREATE)
                    begin
                        out_valid_next = 1'b1;
                        if (free_found)
                        begin
                            in_use_next[free_idx] = 1'b1;
                            meta_we           = 1'b1;
                            meta_waddr        = free_idx;
                            meta_wr           = '0;
                            meta_wr.owner     = q_cmd.owner_id;
                            out_next.new_port = 6'(free_idx);
                        end
                        else
                        begin
                            out_next.status = mpmb_pkg::ST_NO_FREE;
                        end
                    end
                    else if (!(q_cmd.in_range && in_use_reg[q_idx]))
                    begin
                        out_valid_next  = 1'b1;
                        out_next.status = mpmb_pkg::ST_INVALID;
                    end
                    else if (q_cmd.kind == mpmb_pkg::KIND_CLOSE)
                    begin
                        out_valid_next     = 1'b1;
                        in_use_next[q_idx] = 1'b0;
                    end
                    else
                    begin
                        meta_re    = 1'b1;
                        state_next = mpmb_pkg::BK_META;
                    end
                end
            end
            mpmb_pkg::BK_META:
            begin
                if (out_free)
                begin
                    out_next.status   = mpmb_pkg::ST_OK;
                    out_next.new_port = '0;
                    out_next.received = '0;
                    state_next        = mpmb_pkg::BK_IDLE;
                    if (cur_reg.kind == mpmb_pkg::KIND_SEND)
                    begin
                        out_valid_next = 1'b1;
                        if (meta.fill == FILL_W'(RING_DEPTH))
                        begin
                            out_next.status = mpmb_pkg::ST_FULL;
                        end
                        else
                        begin
                            slot_we      = 1'b1;
                            meta_we      = 1'b1;
                            meta_wr.wptr = ptr_inc(meta.wptr);
                            meta_wr.fill = meta.fill + FILL_W'(1);
                        end
                    end
                    else if (meta.fill == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_next.status = mpmb_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        slot_re      = 1'b1;
                        meta_we      = 1'b1;
                        meta_wr.rptr = ptr_inc(meta.rptr);
                        meta_wr.fill = meta.fill - FILL_W'(1);
                        state_next   = mpmb_pkg::BK_SLOT;
                    end
                end
            end
            mpmb_pkg::BK_SLOT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.status   = mpmb_pkg::ST_OK;
                    out_next.new_port = '0;
                    out_next.received = 64'(slot_rdata);
                    state_next        = mpmb_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mpmb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpmb_pkg::BK_IDLE;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    mpmb_ram #(
        .WIDTH (META_W),
        .DEPTH (PORTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (META_W'(meta_wr)),
        .re    (meta_re),
        .raddr (q_idx),
        .rdata (meta_rdata)
    );

    mpmb_ram #(
        .WIDTH (MSG_BITS),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (cur_reg.message[MSG_BITS-1:0]),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

endmodule

@@ hdl/message_port_mailbox_bank.sv @@
`timescale 1ns / 1ps

// A bank of message ports, each a ring buffer of RING_DEPTH words of MSG_BITS bits.
// The request channel (req_valid, req_stall, req) carries create, send, receive
// and close words; the response channel (rsp_valid, rsp_stall, rsp) returns
// exactly one word per request, in request order.
// Requests enter a two-entry queue, so the block keeps accepting while the
// executing side works or while a finished response waits to be taken.
// Create, close and any request on an invalid port are answered from the idle
// state; send also passes the pointer-read state, and receive the pointer-read
// and message-read states, set by the registered read of the per-port pointer
// memory and of the message memory.
// Create picks the lowest free port above port 0 from the per-port in-use flags.
// Reset clears the in-use flags, the queue and the response valid flag at once;
// no clearing pass is needed and the block accepts requests right after reset.
// While a valid response is stalled, the response word holds and no further
// request is executed; up to two requests are still accepted before req_stall rises.
module message_port_mailbox_bank #(
    parameter int PORTS      = mpmb_pkg::PORTS_DEFAULT,
    parameter int RING_DEPTH = mpmb_pkg::RING_DEPTH_DEFAULT,
    parameter int MSG_BITS   = mpmb_pkg::MSG_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mpmb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mpmb_pkg::rsp_t rsp
);

    logic           q_full;
    logic           push;
    mpmb_pkg::cmd_t push_cmd;
    logic           q_valid;
    logic           q_pop;
    mpmb_pkg::cmd_t q_head;

    mpmb_front #(
        .PORTS (PORTS)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    mpmb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    mpmb_back #(
        .PORTS      (PORTS),
        .RING_DEPTH (RING_DEPTH),
        .MSG_BITS   (MSG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ sim/mpmb_checker.sv @@
`timescale 1ns / 1ps

module mpmb_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  mpmb_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  mpmb_pkg::rsp_t rsp,
    output int             fail_count,
    output int             outstanding
);

    import mpmb_pkg::*;

    localparam int NPORT = 64;
    localparam int DEPTH = 16;

    logic        port_open  [NPORT];
    logic [15:0] port_owner [NPORT];
    logic [3:0]  head       [NPORT];
    logic [3:0]  tail       [NPORT];
    logic [4:0]  count      [NPORT];
    logic [63:0] ring       [NPORT][DEPTH];

    rsp_t rsp_expected[$];
    rsp_t predicted;
    rsp_t oldest;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic free_port(input int p);
        port_open[p]  = 1'b0;
        port_owner[p] = '0;
        head[p]       = '0;
        tail[p]       = '0;
        count[p]      = '0;
    endtask

    task automatic mailbox_predict(input req_t w, output rsp_t r);
        int  h;
        int  p;
        bit  found;
        h = w.port;
        found = 1'b0;
        r.status   = ST_OK;
        r.new_port = '0;
        r.received = '0;
        if (w.kind == KIND_CREATE)
        begin
            r.status = ST_NO_FREE;
            for (p = 1; p < NPORT; p++)
            begin
                if (!found && !port_open[p])
                begin
                    found = 1'b1;
                    free_port(p);
                    port_open[p]  = 1'b1;
                    port_owner[p] = w.owner_id;
                    r.new_port    = p[5:0];
                    r.status      = ST_OK;
                end
            end
        end
        else if (h == 0 || !port_open[h])
        begin
            r.status = ST_INVALID;
        end
        else if (w.kind == KIND_SEND)
        begin
            if (count[h] == DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                ring[h][tail[h]] = w.message;
                tail[h]  = tail[h] + 1'b1;
                count[h] = count[h] + 1'b1;
            end
        end
        else if (w.kind == KIND_RECV)
        begin
            if (count[h] == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.received = ring[h][head[h]];
                head[h]  = head[h] + 1'b1;
                count[h] = count[h] - 1'b1;
            end
        end
        else
        begin
            free_port(h);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NPORT; p++)
            begin
                free_port(p);
            end
            rsp_expected.delete();
            outstanding = 0;
        end
        else
        begin
            // A response never answers a request taken at the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected response word: status %0d new_port %0d received %h",
                                 rsp.status, rsp.new_port, rsp.received);
                    end
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest = rsp_expected.pop_front();
                    if (rsp.status !== oldest.status || rsp.new_port !== oldest.new_port ||
                        rsp.received !== oldest.received)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: expected status %0d new_port %0d received %h",
                                     oldest.status, oldest.new_port, oldest.received);
                            $display("          actual   status %0d new_port %0d received %h",
                                     rsp.status, rsp.new_port, rsp.received);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                mailbox_predict(req, predicted);
                rsp_expected.push_back(predicted);
            end
            outstanding = rsp_expected.size();
        end
    end

endmodule

@@ sim/message_port_mailbox_bank_tb.sv @@
`timescale 1ns / 1ps

module message_port_mailbox_bank_tb;

    import mpmb_pkg::*;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    int        fail_count;
    int        outstanding;
    bit        steady     = 1'b0;
    int        stall_left = 0;
    int        items_sent = 0;
    bit [63:0] opened     = '0;

    message_port_mailbox_bank dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    mpmb_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("FAIL message_port_mailbox_bank");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7)
        begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(6, 30);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n || steady)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= idle_len();
        end
        else
        begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
    end

    function automatic req_t make_word(kind_t k, logic [5:0] p, logic [15:0] o,
                                       logic [63:0] m);
        req_t w;
        w.kind     = k;
        w.port     = p;
        w.owner_id = o;
        w.message  = m;
        return w;
    endfunction

    function automatic logic [63:0] rand_msg();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_owner();
        return 16'($urandom);
    endfunction

    function automatic logic [5:0] pick_open();
        int cand[$];
        for (int p = 1; p < 64; p++)
        begin
            if (opened[p])
            begin
                cand.push_back(p);
            end
        end
        if (cand.size() == 0)
        begin
            return 6'($urandom_range(1, 8));
        end
        return 6'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    task automatic send_word(input req_t w);
        int gap;
        bit found;
        found = 1'b0;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        items_sent = items_sent + 1;
        // Keep a record of open ports so most traffic addresses live mailboxes.
        if (w.kind == KIND_CREATE)
        begin
            for (int p = 1; p < 64; p++)
            begin
                if (!found && !opened[p])
                begin
                    found = 1'b1;
                    opened[p] = 1'b1;
                end
            end
        end
        else if (w.kind == KIND_CLOSE && w.port != 0)
        begin
            opened[w.port] = 1'b0;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic mixed_op();
        int         r;
        kind_t      k;
        logic [5:0] p;
        r = $urandom_range(0, 99);
        k = (r < 10) ? KIND_CREATE : (r < 52) ? KIND_SEND : (r < 90) ? KIND_RECV : KIND_CLOSE;
        r = $urandom_range(0, 9);
        p = (r == 0) ? 6'($urandom_range(0, 63)) : (r == 1) ? 6'($urandom_range(1, 8))
                                                            : pick_open();
        send_word(make_word(k, p, rand_owner(), rand_msg()));
    endtask

    initial
    begin
        logic [5:0] p;
        int         n;
        bit         filled;
        filled = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(make_word(KIND_CREATE, 6'd0, 16'hFFFF, '1));
        send_word(make_word(KIND_CREATE, 6'd63, 16'h0000, '0));
        send_word(make_word(KIND_SEND, 6'd1, '0, '1));
        send_word(make_word(KIND_SEND, 6'd1, '1, '0));
        send_word(make_word(KIND_SEND, 6'd2, 16'h1234, 64'h8000_0000_0000_0001));
        send_word(make_word(KIND_RECV, 6'd1, '0, '0));
        send_word(make_word(KIND_RECV, 6'd1, '0, '1));
        send_word(make_word(KIND_RECV, 6'd1, '0, '0));
        send_word(make_word(KIND_SEND, 6'd0, '0, '1));
        send_word(make_word(KIND_RECV, 6'd0, '0, '0));
        send_word(make_word(KIND_CLOSE, 6'd0, '0, '0));
        send_word(make_word(KIND_SEND, 6'd63, '1, '1));
        send_word(make_word(KIND_RECV, 6'd63, '0, '0));
        send_word(make_word(KIND_CLOSE, 6'd63, '0, '0));
        send_word(make_word(KIND_CLOSE, 6'd1, '0, '0));
        send_word(make_word(KIND_RECV, 6'd1, '0, '0));
        send_word(make_word(KIND_CLOSE, 6'd1, '0, '0));
        send_word(make_word(KIND_CREATE, 6'd5, 16'hA5A5, '0));
        send_word(make_word(KIND_RECV, 6'd2, '0, '0));
        send_word(make_word(KIND_CLOSE, 6'd2, '0, '0));
        send_word(make_word(KIND_CLOSE, 6'd1, '0, '0));

        while (items_sent < 520)
        begin
            steady <= ($urandom_range(0, 4) == 0);
            if (!filled && items_sent > 250)
            begin
                // Exhaust the bank, overflow it with creates, then free every port.
                drain();
                filled = 1'b1;
                n = 63 - $countones(opened) + 2;
                repeat (n) send_word(make_word(KIND_CREATE, 6'($urandom), rand_owner(),
                                               rand_msg()));
                for (int q = 63; q >= 1; q--)
                begin
                    send_word(make_word(KIND_CLOSE, 6'(q), rand_owner(), rand_msg()));
                end
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    repeat ($urandom_range(1, 8)) mixed_op();
                end
                6:
                begin
                    if ($countones(opened) == 0)
                    begin
                        send_word(make_word(KIND_CREATE, '0, rand_owner(), rand_msg()));
                    end
                    p = pick_open();
                    n = $urandom_range(14, 18);
                    repeat (n) send_word(make_word(KIND_SEND, p, rand_owner(), rand_msg()));
                    repeat (n + 1) send_word(make_word(KIND_RECV, p, rand_owner(),
                                                       rand_msg()));
                end
                7:
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(make_word(kind_t'($urandom_range(0, 3)),
                                            6'($urandom_range(0, 63)), rand_owner(),
                                            rand_msg()));
                end
                8:
                begin
                    send_word(make_word(KIND_CLOSE, pick_open(), rand_owner(), rand_msg()));
                end
                default:
                begin
                    send_word(make_word(KIND_CREATE, 6'($urandom), rand_owner(), rand_msg()));
                    repeat ($urandom_range(1, 4)) mixed_op();
                end
            endcase
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS message_port_mailbox_bank");
        end
        else
        begin
            $display("FAIL message_port_mailbox_bank");
        end
        $finish;
    end

endmodule
